/* rtl/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types, codes and helpers for the set associative cache LRU simulator.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int AGE_W   = 3;
    localparam int CNT_W   = 32;
    localparam int REQ_W   = 2;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 6;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_WAYS       = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic load_req;
        logic read;
        logic update;
        logic last;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
        return (a == AGE_MAX) ? a : a + AGE_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

/* rtl/set_assoc_cache_lru_sim_unit.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_unit
// Set associative cache hit/miss simulator with true LRU replacement.
// ----------------------------------------------------------------------------
// Each access reads the set's row (tags, ages, valid flags of all ways)
// from the single-port set memory, then compares, picks the hit, fill or
// victim way and writes the row back. Load and store run one access per
// request, modify runs two, and a reserved request kind is consumed with
// no result. A new request is taken in the cycle that the
// last write-back of the previous one happens. Results sit in an output
// register, so the next access runs while a result waits; an access stalls
// in its write-back cycle only while that register is full and not taken.
// No clearing pass after reset: a flag per set marks rows never written,
// which read as all lines invalid.
module set_assoc_cache_lru_sim_unit #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sacl_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [sacl_pkg::CDAT_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sacl_pkg::REQ_W-1:0]    i_req_type,
    input  logic [63:0]                   i_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic                          o_miss,
    output logic                          o_evict,
    output logic                          o_last,
    output logic [sacl_pkg::CNT_W-1:0]    o_hit_count,
    output logic [sacl_pkg::CNT_W-1:0]    o_miss_count,
    output logic [sacl_pkg::CNT_W-1:0]    o_evict_count
);

    sacl_pkg::t_ctl_cmd   cmd;
    sacl_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    sacl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sacl_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_address     (i_address),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_hit         (o_hit),
        .o_miss        (o_miss),
        .o_evict       (o_evict),
        .o_last        (o_last),
        .o_hit_count   (o_hit_count),
        .o_miss_count  (o_miss_count),
        .o_evict_count (o_evict_count)
    );

endmodule

/* rtl/sacl_ctrl.sv */
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: takes a request, runs one or two read/update passes per access request, none for a reserved kind.
// ----------------------------------------------------------------------------
module sacl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [sacl_pkg::REQ_W-1:0]    i_req_type,
    output logic                          o_in_ready,
    input  sacl_pkg::t_dp_status          i_status,
    output sacl_pkg::t_ctl_cmd            o_cmd
);

    sacl_pkg::t_state r_state, n_state;
    logic             r_two, n_two;
    logic             is_access;
    logic             is_modify;

    assign is_modify = (i_req_type == sacl_pkg::REQ_MODIFY);
    assign is_access = (i_req_type == sacl_pkg::REQ_LOAD) ||
                       (i_req_type == sacl_pkg::REQ_STORE) || is_modify;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacl_pkg::ST_IDLE;
            r_two   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_two   <= n_two;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_two      = r_two;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sacl_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    if (is_access) begin
                        n_state = sacl_pkg::ST_READ;
                        n_two   = is_modify;
                    end
                end
            end
            sacl_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = sacl_pkg::ST_UPDATE;
            end
            sacl_pkg::ST_UPDATE: begin
                if (i_status.out_free) begin
                    o_cmd.update = 1'b1;
                    o_cmd.last   = !r_two;
                    if (r_two) begin
                        n_two   = 1'b0;
                        n_state = sacl_pkg::ST_READ;
                    end else begin
                        o_in_ready = 1'b1;
                        n_state    = sacl_pkg::ST_IDLE;
                        if (i_in_valid) begin
                            o_cmd.load_req = 1'b1;
                            if (is_access) begin
                                n_state = sacl_pkg::ST_READ;
                                n_two   = is_modify;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = sacl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sacl_dp.sv */
// ----------------------------------------------------------------------------
// sacl_dp
// Datapath: config registers, set row memories, lookup and LRU update,
// saturating counters and the result register.
// ----------------------------------------------------------------------------
module sacl_dp #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [sacl_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [sacl_pkg::CDAT_W-1:0]   i_cfg_data,
    input  sacl_pkg::t_ctl_cmd            i_cmd,
    output sacl_pkg::t_dp_status          o_status,
    input  logic [63:0]                   i_address,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_hit,
    output logic                          o_miss,
    output logic                          o_evict,
    output logic                          o_last,
    output logic [sacl_pkg::CNT_W-1:0]    o_hit_count,
    output logic [sacl_pkg::CNT_W-1:0]    o_miss_count,
    output logic [sacl_pkg::CNT_W-1:0]    o_evict_count
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SH_W     = 7;
    localparam int AGE_W    = sacl_pkg::AGE_W;
    localparam int CNT_W    = sacl_pkg::CNT_W;

    // config
    logic [2:0] r_set_bits;
    logic [5:0] r_block_bits;
    logic [3:0] r_ways;
    logic [2:0] set_eff;
    logic [3:0] ways_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways       <= 4'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sacl_pkg::CFG_SET_BITS:   r_set_bits   <= i_cfg_data[2:0];
                sacl_pkg::CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                sacl_pkg::CFG_WAYS:       r_ways       <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign set_eff  = (int'(r_set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : r_set_bits;
    assign ways_eff = (r_ways == 4'd0) ? 4'd1 :
                      ((int'(r_ways) > MAX_WAYS) ? 4'(MAX_WAYS) : r_ways);

    // request address and split
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [SH_W-1:0]       tag_sh;
    logic [ADDR_WIDTH-1:0] tag_calc;
    logic [ADDR_WIDTH-1:0] set_sh;
    logic [SET_W-1:0]      set_calc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_addr <= i_address[ADDR_WIDTH-1:0];
        end
    end

    assign tag_sh   = SH_W'(set_eff) + SH_W'(r_block_bits);
    assign tag_calc = r_addr >> tag_sh;
    assign set_sh   = r_addr >> r_block_bits;

    always_comb begin
        for (int i = 0; i < SET_W; i++) begin
            set_calc[i] = set_sh[i] && (i < int'(set_eff));
        end
    end

    // set row memories
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] r_mem_tag [NUM_SETS];
    logic [MAX_WAYS-1:0][AGE_W-1:0]      r_mem_age [NUM_SETS];
    logic [MAX_WAYS-1:0]                 r_mem_vld [NUM_SETS];
    logic [NUM_SETS-1:0]                 r_row_ok;

    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] r_rd_tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      r_rd_age;
    logic [MAX_WAYS-1:0]                 r_rd_vld;
    logic                                r_rd_ok;
    logic [ADDR_WIDTH-1:0]               r_tag;
    logic [SET_W-1:0]                    r_set;

    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] n_tag_row;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      n_age_row;
    logic [MAX_WAYS-1:0]                 n_vld_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_tag <= r_mem_tag[set_calc];
            r_rd_age <= r_mem_age[set_calc];
            r_rd_vld <= r_mem_vld[set_calc];
            r_tag    <= tag_calc;
            r_set    <= set_calc;
        end
        if (i_cmd.update) begin
            r_mem_tag[r_set] <= n_tag_row;
            r_mem_age[r_set] <= n_age_row;
            r_mem_vld[r_set] <= n_vld_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_cmd.read) begin
                r_rd_ok <= r_row_ok[set_calc];
            end
            if (i_cmd.update) begin
                r_row_ok[r_set] <= 1'b1;
            end
        end
    end

    // lookup and lru update
    logic [MAX_WAYS-1:0][AGE_W-1:0] cur_age;
    logic [MAX_WAYS-1:0]            cur_vld;
    logic [MAX_WAYS-1:0]            in_use;
    logic                           hit_found;
    logic                           free_found;
    logic [WAY_W-1:0]               hit_way;
    logic [WAY_W-1:0]               free_way;
    logic [WAY_W-1:0]               victim;
    logic [AGE_W-1:0]               best;
    logic [AGE_W-1:0]               hit_age;
    logic [WAY_W-1:0]               sel_way;
    logic                           evict;

    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        victim     = '0;
        best       = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            cur_vld[w] = r_rd_ok && r_rd_vld[w];
            cur_age[w] = r_rd_ok ? r_rd_age[w] : '0;
            in_use[w]  = (w < int'(ways_eff));
            if (in_use[w] && cur_vld[w] && (r_rd_tag[w] == r_tag) && !hit_found) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (in_use[w] && !cur_vld[w] && !free_found) begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
            if (in_use[w] && ((w == 0) || (cur_age[w] > best))) begin
                best   = cur_age[w];
                victim = WAY_W'(w);
            end
        end
        hit_age = cur_age[hit_way];
        evict   = !hit_found && !free_found;
        sel_way = hit_found ? hit_way : (free_found ? free_way : victim);
        n_tag_row = r_rd_tag;
        n_age_row = cur_age;
        n_vld_row = cur_vld;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w] && cur_vld[w] && (WAY_W'(w) != sel_way)) begin
                if (!hit_found || (cur_age[w] < hit_age)) begin
                    n_age_row[w] = sacl_pkg::age_inc(cur_age[w]);
                end
            end
        end
        n_age_row[sel_way] = '0;
        if (!hit_found) begin
            n_vld_row[sel_way] = 1'b1;
            n_tag_row[sel_way] = r_tag;
        end
    end

    // counters
    logic [CNT_W-1:0] r_hit_cnt, r_miss_cnt, r_evict_cnt;
    logic [CNT_W-1:0] n_hit_cnt, n_miss_cnt, n_evict_cnt;

    assign n_hit_cnt   = hit_found ? sacl_pkg::sat_inc(r_hit_cnt) : r_hit_cnt;
    assign n_miss_cnt  = hit_found ? r_miss_cnt : sacl_pkg::sat_inc(r_miss_cnt);
    assign n_evict_cnt = evict ? sacl_pkg::sat_inc(r_evict_cnt) : r_evict_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else if (i_cmd.update) begin
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_evict_cnt <= n_evict_cnt;
        end
    end

    // result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_hit         <= hit_found;
            o_miss        <= !hit_found;
            o_evict       <= evict;
            o_last        <= i_cmd.last;
            o_hit_count   <= n_hit_cnt;
            o_miss_count  <= n_miss_cnt;
            o_evict_count <= n_evict_cnt;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

/* rtl/sacl_chk.sv */
// ----------------------------------------------------------------------------
// sacl_chk
// Port-level checks for the cache simulator, bound to the top level.
// ----------------------------------------------------------------------------
module sacl_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_hit,
    input logic                          o_miss,
    input logic                          o_evict,
    input logic [sacl_pkg::CNT_W-1:0]    o_hit_count,
    input logic [sacl_pkg::CNT_W-1:0]    o_miss_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_hit_xor_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hit != o_miss))
        else $error("hit and miss not exclusive");

    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evict |-> o_miss)
        else $error("eviction reported on a hit");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_hit && (o_hit_count != '0)) ||
                         (o_miss && (o_miss_count != '0))))
        else $error("running count does not include this access");

endmodule

bind set_assoc_cache_lru_sim_unit sacl_chk u_sacl_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_hit        (o_hit),
    .o_miss       (o_miss),
    .o_evict      (o_evict),
    .o_hit_count  (o_hit_count),
    .o_miss_count (o_miss_count)
);

/* bench/tb_set_assoc_cache_lru_sim_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_sim_unit
// Self-checking bench for the set associative cache LRU hit/miss simulator.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and sent by a clocked driver.
// A clocked monitor predicts each accepted request with a private copy of
// the cache tags, valid flags, LRU ages and counters. It then checks every
// result against the oldest prediction, field by field. The run steps
// through several cache shapes, including out of range and wide shift
// settings, with random sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_sim_unit;

    localparam int SET_LIMIT = 6;
    localparam int WAY_LIMIT = 8;
    localparam int LINES     = (1 << SET_LIMIT) * WAY_LIMIT;
    localparam int DAT_W     = sacl_pkg::CDAT_W;

    localparam logic [sacl_pkg::REQ_W-1:0]  REQ_RSVD  = 2'd3;
    localparam logic [sacl_pkg::CIDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [sacl_pkg::REQ_W-1:0] kind;
        logic [63:0]                addr;
    } t_req;

    typedef struct {
        bit                       hit;
        bit                       miss;
        bit                       evict;
        bit                       last;
        bit [sacl_pkg::CNT_W-1:0] hits;
        bit [sacl_pkg::CNT_W-1:0] misses;
        bit [sacl_pkg::CNT_W-1:0] evicts;
    } t_outcome;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [sacl_pkg::CIDX_W-1:0]   i_cfg_index = '0;
    logic [sacl_pkg::CDAT_W-1:0]   i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic [sacl_pkg::REQ_W-1:0]    i_req_type = '0;
    logic [63:0]                   i_address = '0;
    logic                          i_out_ready = 1'b0;
    logic                          o_cfg_ready;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic                          o_hit;
    logic                          o_miss;
    logic                          o_evict;
    logic                          o_last;
    logic [sacl_pkg::CNT_W-1:0]    o_hit_count;
    logic [sacl_pkg::CNT_W-1:0]    o_miss_count;
    logic [sacl_pkg::CNT_W-1:0]    o_evict_count;

    set_assoc_cache_lru_sim_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit),
        .o_miss       (o_miss),
        .o_evict      (o_evict),
        .o_last       (o_last),
        .o_hit_count  (o_hit_count),
        .o_miss_count (o_miss_count),
        .o_evict_count(o_evict_count)
    );

    // cache image kept by the bench
    bit                       line_ok  [LINES];
    bit [63:0]                line_tag [LINES];
    bit [sacl_pkg::AGE_W-1:0] line_age [LINES];
    bit [sacl_pkg::CNT_W-1:0] hits_seen_total;
    bit [sacl_pkg::CNT_W-1:0] misses_seen_total;
    bit [sacl_pkg::CNT_W-1:0] evicts_seen_total;
    bit [2:0]       cur_set_bits = 3'd0;
    bit [5:0]       cur_block_bits = 6'd0;
    bit [3:0]       cur_ways = 4'd1;

    t_req     requests[$];
    t_outcome outcome_q[$];
    t_req     next_req;
    bit       in_taken = 1'b0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       errors = 0;
    int       n_accepted = 0;
    int       n_ignored = 0;
    int       n_results = 0;
    int       n_hits = 0;
    int       n_misses = 0;
    int       n_evicts = 0;
    int       n_settings = 0;
    bit [63:0] tag_pool[10];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit [sacl_pkg::AGE_W-1:0] age_up(input bit [sacl_pkg::AGE_W-1:0] a);
        return (a == sacl_pkg::AGE_MAX) ? a : a + 1'b1;
    endfunction

    function automatic bit [sacl_pkg::CNT_W-1:0] count_up(input bit [sacl_pkg::CNT_W-1:0] v);
        return (v == sacl_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    // one cache access: look up, update LRU state, queue the expected word
    function automatic void lru_lookup(input bit [63:0] addr, input bit is_last);
        int       s;
        int       b;
        int       ways;
        int       base;
        int       hit_way;
        int       fill_way;
        int       victim;
        int       tgt;
        bit [63:0] tag;
        bit [63:0] set_idx;
        bit       found;
        bit       have_free;
        bit       evicted;
        bit [sacl_pkg::AGE_W-1:0] best;
        bit [sacl_pkg::AGE_W-1:0] a;
        t_outcome r;
        s = (cur_set_bits > SET_LIMIT) ? SET_LIMIT : cur_set_bits;
        b = cur_block_bits;
        ways = (cur_ways == 0) ? 1 : cur_ways;
        if (ways > WAY_LIMIT) ways = WAY_LIMIT;
        tag = (s + b >= 64) ? 64'd0 : (addr >> (s + b));
        set_idx = (b >= 64) ? 64'd0 : ((addr >> b) & ((64'd1 << s) - 64'd1));
        base = int'(set_idx) * WAY_LIMIT;
        found = 0;
        have_free = 0;
        evicted = 0;
        hit_way = 0;
        fill_way = 0;
        victim = 0;
        best = 0;
        for (int w = 0; w < ways; w++) begin
            if (line_ok[base + w] && line_tag[base + w] == tag && !found) begin
                found = 1;
                hit_way = w;
            end
            if (!line_ok[base + w] && !have_free) begin
                have_free = 1;
                fill_way = w;
            end
        end
        if (found) begin
            a = line_age[base + hit_way];
            for (int w = 0; w < ways; w++)
                if (w != hit_way && line_ok[base + w] && line_age[base + w] < a)
                    line_age[base + w] = age_up(line_age[base + w]);
            line_age[base + hit_way] = 0;
            hits_seen_total = count_up(hits_seen_total);
        end else begin
            misses_seen_total = count_up(misses_seen_total);
            if (have_free) begin
                tgt = fill_way;
            end else begin
                for (int w = 0; w < ways; w++) begin
                    if (line_age[base + w] > best || w == 0) begin
                        best = line_age[base + w];
                        victim = w;
                    end
                end
                tgt = victim;
                evicted = 1;
                evicts_seen_total = count_up(evicts_seen_total);
            end
            for (int w = 0; w < ways; w++)
                if (w != tgt && line_ok[base + w])
                    line_age[base + w] = age_up(line_age[base + w]);
            line_ok[base + tgt] = 1;
            line_tag[base + tgt] = tag;
            line_age[base + tgt] = 0;
        end
        r.hit = found;
        r.miss = !found;
        r.evict = evicted;
        r.last = is_last;
        r.hits = hits_seen_total;
        r.misses = misses_seen_total;
        r.evicts = evicts_seen_total;
        outcome_q.push_back(r);
    endfunction

    function automatic void check_field(input string name, input bit [63:0] want,
                                        input bit [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = requests.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= next_req.kind;
                i_address <= next_req.addr;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor and predictor
    always @(posedge i_clk) begin : mon
        t_outcome want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                n_results++;
                n_hits += o_hit;
                n_misses += o_miss;
                n_evicts += o_evict;
                if (outcome_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual hit=%0b miss=%0b",
                             $time, o_hit, o_miss);
                end else begin
                    want = outcome_q.pop_front();
                    check_field("hit", want.hit, o_hit);
                    check_field("miss", want.miss, o_miss);
                    check_field("evict", want.evict, o_evict);
                    check_field("last", want.last, o_last);
                    check_field("hit_count", want.hits, o_hit_count);
                    check_field("miss_count", want.misses, o_miss_count);
                    check_field("evict_count", want.evicts, o_evict_count);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sacl_pkg::CFG_SET_BITS: begin
                        cur_set_bits = i_cfg_data[2:0];
                    end
                    sacl_pkg::CFG_BLOCK_BITS: begin
                        cur_block_bits = i_cfg_data;
                    end
                    sacl_pkg::CFG_WAYS: begin
                        cur_ways = i_cfg_data[3:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                n_accepted++;
                if (i_req_type == sacl_pkg::REQ_LOAD || i_req_type == sacl_pkg::REQ_STORE) begin
                    lru_lookup(i_address, 1'b1);
                end else if (i_req_type == sacl_pkg::REQ_MODIFY) begin
                    lru_lookup(i_address, 1'b0);
                    lru_lookup(i_address, 1'b1);
                end else begin
                    n_ignored++;
                end
            end
        end
    end

    task automatic cfg_write(input logic [sacl_pkg::CIDX_W-1:0] idx,
                             input logic [sacl_pkg::CDAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (requests.size() != 0 || i_in_valid || outcome_q.size() != 0);
        // reserved requests leave nothing to wait for, so let the pipe drain before going on
        repeat (10) @(negedge i_clk);
    endtask

    task automatic push_req(input logic [sacl_pkg::REQ_W-1:0] kind, input logic [63:0] addr);
        t_req r;
        r.kind = kind;
        r.addr = addr;
        requests.push_back(r);
    endtask

    function automatic logic [sacl_pkg::REQ_W-1:0] pick_kind();
        int p;
        p = $urandom_range(99);
        if (p < 35) return sacl_pkg::REQ_LOAD;
        if (p < 65) return sacl_pkg::REQ_STORE;
        if (p < 95) return sacl_pkg::REQ_MODIFY;
        return REQ_RSVD;
    endfunction

    // addresses built from a small tag pool and a few sets so lines get reused
    function automatic logic [63:0] pick_address(input int s, input int b, input int w);
        logic [63:0] a;
        logic [63:0] si;
        int          ti;
        if ($urandom_range(9) == 0) return {$urandom, $urandom};
        ti = $urandom_range(w + 1);
        si = ($urandom_range(3) == 0) ? 64'($urandom) : 64'($urandom_range(3));
        a = {$urandom, $urandom} & ((64'd1 << b) - 64'd1);
        a |= (si & ((64'd1 << s) - 64'd1)) << b;
        if (s + b < 64) a |= tag_pool[ti] << (s + b);
        return a;
    endfunction

    task automatic run_phase(input int sb, input int bb, input int wy, input int n,
                             input int mode);
        int s_eff;
        int w_eff;
        s_eff = (sb > SET_LIMIT) ? SET_LIMIT : sb;
        w_eff = (wy == 0) ? 1 : ((wy > WAY_LIMIT) ? WAY_LIMIT : wy);
        cfg_write(sacl_pkg::CFG_SET_BITS, DAT_W'(sb));
        cfg_write(sacl_pkg::CFG_BLOCK_BITS, DAT_W'(bb));
        cfg_write(sacl_pkg::CFG_WAYS, DAT_W'(wy));
        n_settings++;
        for (int i = 0; i < 10; i++) tag_pool[i] = {$urandom, $urandom};
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
        for (int i = 0; i < n / 2; i++) push_req(pick_kind(), pick_address(s_eff, bb, w_eff));
        // the second half is queued only after the cache has answered everything
        wait_idle();
        for (int i = n / 2; i < n; i++) push_req(pick_kind(), pick_address(s_eff, bb, w_eff));
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset shape: one set, one way, byte blocks
        push_req(sacl_pkg::REQ_LOAD, 64'd0);
        push_req(sacl_pkg::REQ_LOAD, 64'd0);
        push_req(sacl_pkg::REQ_STORE, '1);
        push_req(sacl_pkg::REQ_MODIFY, '1);
        push_req(sacl_pkg::REQ_MODIFY, 64'h5555_5555_5555_5555);
        push_req(REQ_RSVD, '1);
        push_req(sacl_pkg::REQ_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
        push_req(sacl_pkg::REQ_STORE, 64'h5555_5555_5555_5555);
        push_req(sacl_pkg::REQ_MODIFY, 64'd0);
        push_req(sacl_pkg::REQ_LOAD, 64'h8000_0000_0000_0000);
        push_req(sacl_pkg::REQ_LOAD, 64'd1);
        wait_idle();

        // widest shape: overfill one set to force LRU eviction
        cfg_write(sacl_pkg::CFG_SET_BITS, 6'd6);
        cfg_write(sacl_pkg::CFG_BLOCK_BITS, 6'd6);
        cfg_write(sacl_pkg::CFG_WAYS, 6'd8);
        cfg_write(CFG_SPARE, '1);
        n_settings += 2;
        for (int k = 0; k < 9; k++) push_req(sacl_pkg::REQ_LOAD, 64'(k) << 12);
        push_req(sacl_pkg::REQ_STORE, 64'd1 << 12);
        push_req(sacl_pkg::REQ_LOAD, 64'd0);
        push_req(sacl_pkg::REQ_MODIFY, 64'd2 << 12);
        wait_idle();

        run_phase(2, 4, 4, 135, 0);
        run_phase(6, 6, 8, 135, 1);
        run_phase(7, 0, 15, 135, 2);
        run_phase(0, 0, 0, 135, 3);
        run_phase(1, 63, 2, 135, 0);
        run_phase(6, 58, 3, 135, 3);
        run_phase(3, 32, 8, 135, 2);
        run_phase(4, 12, 5, 135, 1);

        $display("covered %0d requests (%0d of reserved kind) over %0d cache shapes",
                 n_accepted, n_ignored, n_settings);
        $display("checked %0d words: %0d hits, %0d misses, %0d evictions",
                 n_results, n_hits, n_misses, n_evicts);
        if (errors == 0 && outcome_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/sacl_pkg.sv
rtl/sacl_ctrl.sv
rtl/sacl_dp.sv
rtl/set_assoc_cache_lru_sim_unit.sv
rtl/sacl_chk.sv
bench/tb_set_assoc_cache_lru_sim_unit.sv
